FILE: hw/rtl/scfp_pkg.sv
// Shared types and constants of the serial command frame parser.
package scfp_pkg;

  localparam logic [7:0] CHAR_FRAME_END = 8'h3B;
  localparam logic [7:0] CHAR_SEPARATOR = 8'h20;
  localparam logic [7:0] CHAR_PLUS      = 8'h2B;
  localparam logic [7:0] CHAR_MINUS     = 8'h2D;
  localparam logic [7:0] CHAR_ZERO      = 8'h30;
  localparam logic [7:0] CHAR_NINE      = 8'h39;
  localparam logic [7:0] CHAR_WS_LO     = 8'h09;
  localparam logic [7:0] CHAR_WS_HI     = 8'h0D;

  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 64;
  localparam int CFG_COUNT_W  = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_COMMAND_CHARS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COMMAND_COUNT = 1'd1;

  // tuser bit positions of the result channel
  localparam int USER_HAS_DATA  = 0;
  localparam int USER_TRUNCATED = 1;
  localparam int OUT_USER_W     = 2;

  typedef enum logic [1:0] {
    PH_WAIT,
    PH_SIGN,
    PH_DIGITS,
    PH_DONE
  } lane_phase_t;

  typedef enum logic [2:0] {
    TP_BEFORE,
    TP_HEADER,
    TP_BETWEEN,
    TP_DATA,
    TP_AFTER
  } tok_pos_t;

endpackage

FILE: hw/rtl/serial_command_frame_parser.sv
// Top level: frame splitter, per-lane index parser on a shared multiply-add unit, data drain.
// A data or separator byte is taken in the idle state; a header byte then visits every lane,
//   the lanes being stepped one per cycle through a single multiply-by-ten/add/saturate unit.
// A ';' passes accept, lane select and index form, then one drain step per record, each record
//   waiting on out_tready, or stops after lane select on no match; in_tready is low throughout.
// Reset (rst_n low at a clock edge) clears configuration, frame state and output valid only.
module serial_command_frame_parser #(
  parameter int MAX_COMMANDS = 8,
  parameter int DATA_DEPTH   = 32,
  parameter int INDEX_WIDTH  = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [7:0]                             in_tdata,   // in_byte
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // command character, cmd_index, data_byte; zero padded to whole bytes
  output logic [((16+INDEX_WIDTH+7)/8)*8-1:0]    out_tdata,
  output logic [scfp_pkg::OUT_USER_W-1:0]        out_tuser,  // has_data, data_truncated
  output logic                                   out_tlast,
  input  logic                                   cfg_we,
  input  logic [scfp_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [scfp_pkg::CFG_DATA_W-1:0]        cfg_wdata
);
  import scfp_pkg::*;

  localparam int LANE_W = (MAX_COMMANDS > 1) ? $clog2(MAX_COMMANDS) : 1;
  localparam int AW     = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;
  localparam int LW     = $clog2(DATA_DEPTH + 1);
  localparam int W      = INDEX_WIDTH;
  localparam int MW     = INDEX_WIDTH + 4;
  localparam logic [W-1:0] LIMIT  = W'(1) << (W - 1);
  localparam logic [LANE_W-1:0] LAST_LANE = LANE_W'(MAX_COMMANDS - 1);
  localparam logic [LW-1:0] DEPTH_L = LW'(DATA_DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LANES,
    ST_FIND,
    ST_INDEX,
    ST_DRAIN
  } state_t;

  state_t                 state_r;
  logic [CFG_DATA_W-1:0]  command_chars_r;
  logic [CFG_COUNT_W-1:0] command_count_r;

  logic                   lane_seen_r     [MAX_COMMANDS];
  lane_phase_t            lane_phase_r    [MAX_COMMANDS];
  logic                   lane_negative_r [MAX_COMMANDS];
  logic [W-1:0]           lane_value_r    [MAX_COMMANDS];

  tok_pos_t               tok_pos_r;
  logic [LW-1:0]          data_length_r;
  logic                   overflow_r;
  logic [7:0]             data_store [DATA_DEPTH];

  logic [7:0]             byte_r;
  logic [LANE_W-1:0]      lane_idx_r;
  logic [LANE_W-1:0]      sel_r;
  logic [7:0]             cmd_sym_r;
  logic [W-1:0]           cmd_index_r;
  logic [LW-1:0]          drain_k_r;

  logic                   out_valid_r;
  logic [7:0]             out_char_r;
  logic [W-1:0]           out_index_r;
  logic [7:0]             out_data_r;
  logic                   out_has_r;
  logic                   out_trunc_r;
  logic                   out_last_r;

  // input side decode
  logic                   in_acc;
  tok_pos_t               tok_pos_nxt;
  logic                   data_wr;

  // shared lane unit
  logic                   lane_active;
  logic [7:0]             lane_char;
  logic                   is_digit;
  logic [MW-1:0]          mac;
  logic [W-1:0]           mac_sat;
  logic                   seen_nxt;
  lane_phase_t            phase_nxt;
  logic                   neg_nxt;
  logic [W-1:0]           value_nxt;

  // frame end
  logic                   found;
  logic [LANE_W-1:0]      found_idx;
  logic [W-1:0]           index_nxt;
  logic                   out_free;
  logic [LW-1:0]          total_m1;
  logic                   drain_last;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    tok_pos_nxt = tok_pos_r;
    if (in_tdata == CHAR_SEPARATOR) begin
      if (tok_pos_r == TP_HEADER) tok_pos_nxt = TP_BETWEEN;
      else if (tok_pos_r == TP_DATA) tok_pos_nxt = TP_AFTER;
    end else if (tok_pos_r == TP_BEFORE) begin
      tok_pos_nxt = TP_HEADER;
    end else if (tok_pos_r == TP_BETWEEN) begin
      tok_pos_nxt = TP_DATA;
    end
  end

  assign data_wr = in_acc && (in_tdata != CHAR_FRAME_END) && (in_tdata != CHAR_SEPARATOR) &&
                   (tok_pos_nxt == TP_DATA) && (data_length_r != DEPTH_L);

  // one lane per cycle through the multiply-by-ten, add and saturate unit
  assign lane_active = (CFG_COUNT_W'(lane_idx_r) < command_count_r);
  assign lane_char   = command_chars_r[{lane_idx_r, 3'b000} +: 8];
  assign is_digit    = (byte_r >= CHAR_ZERO) && (byte_r <= CHAR_NINE);
  assign mac         = MW'({lane_value_r[lane_idx_r], 3'b000})
                       + MW'({lane_value_r[lane_idx_r], 1'b0})
                       + MW'(byte_r[3:0]);
  assign mac_sat     = (mac > MW'(LIMIT)) ? LIMIT : mac[W-1:0];

  always_comb begin
    seen_nxt  = lane_seen_r[lane_idx_r];
    phase_nxt = lane_phase_r[lane_idx_r];
    neg_nxt   = lane_negative_r[lane_idx_r];
    value_nxt = lane_value_r[lane_idx_r];
    if (lane_active) begin
      if (!lane_seen_r[lane_idx_r]) begin
        if (byte_r == lane_char) begin
          seen_nxt  = 1'b1;
          phase_nxt = PH_WAIT;
          neg_nxt   = 1'b0;
          value_nxt = '0;
        end
      end else if (lane_phase_r[lane_idx_r] != PH_DONE) begin
        if (is_digit) begin
          value_nxt = mac_sat;
          phase_nxt = PH_DIGITS;
        end else if (lane_phase_r[lane_idx_r] == PH_WAIT &&
                     byte_r >= CHAR_WS_LO && byte_r <= CHAR_WS_HI) begin
          phase_nxt = PH_WAIT;
        end else if (lane_phase_r[lane_idx_r] == PH_WAIT &&
                     (byte_r == CHAR_PLUS || byte_r == CHAR_MINUS)) begin
          neg_nxt   = (byte_r == CHAR_MINUS);
          phase_nxt = PH_SIGN;
        end else begin
          phase_nxt = PH_DONE;
        end
      end
    end
  end

  // first seen lane in list order
  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int i = MAX_COMMANDS - 1; i >= 0; i--) begin
      if (lane_seen_r[i] && (CFG_COUNT_W'(i) < command_count_r)) begin
        found     = 1'b1;
        found_idx = LANE_W'(i);
      end
    end
  end

  always_comb begin
    if (lane_negative_r[sel_r]) index_nxt = ~lane_value_r[sel_r] + W'(1);
    else if (lane_value_r[sel_r] >= LIMIT) index_nxt = LIMIT - W'(1);
    else index_nxt = lane_value_r[sel_r];
  end

  assign out_free   = !out_valid_r || out_tready;
  assign total_m1   = (data_length_r == '0) ? '0 : data_length_r - LW'(1);
  assign drain_last = (drain_k_r == total_m1);

  always_ff @(posedge clk) begin
    if (data_wr) data_store[data_length_r[AW-1:0]] <= in_tdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      command_chars_r <= '0;
      command_count_r <= '0;
      tok_pos_r       <= TP_BEFORE;
      data_length_r   <= '0;
      overflow_r      <= 1'b0;
      lane_idx_r      <= '0;
      drain_k_r       <= '0;
      out_valid_r     <= 1'b0;
      for (int i = 0; i < MAX_COMMANDS; i++) begin
        lane_seen_r[i]     <= 1'b0;
        lane_phase_r[i]    <= PH_WAIT;
        lane_negative_r[i] <= 1'b0;
        lane_value_r[i]    <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_COMMAND_CHARS: command_chars_r <= cfg_wdata;
          CFG_COMMAND_COUNT: command_count_r <= cfg_wdata[CFG_COUNT_W-1:0];
          default: ;
        endcase
      end
      // in the drain state the output register is always refilled or held
      if (out_tready && state_r != ST_DRAIN) out_valid_r <= 1'b0;

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            byte_r <= in_tdata;
            if (in_tdata == CHAR_FRAME_END) begin
              state_r <= ST_FIND;
            end else begin
              tok_pos_r <= tok_pos_nxt;
              if (in_tdata != CHAR_SEPARATOR) begin
                if (tok_pos_nxt == TP_HEADER) begin
                  lane_idx_r <= '0;
                  state_r    <= ST_LANES;
                end else if (tok_pos_nxt == TP_DATA) begin
                  if (data_length_r != DEPTH_L) data_length_r <= data_length_r + LW'(1);
                  else overflow_r <= 1'b1;
                end
              end
            end
          end
        end
        ST_LANES: begin
          lane_seen_r[lane_idx_r]     <= seen_nxt;
          lane_phase_r[lane_idx_r]    <= phase_nxt;
          lane_negative_r[lane_idx_r] <= neg_nxt;
          lane_value_r[lane_idx_r]    <= value_nxt;
          if (lane_idx_r == LAST_LANE) state_r <= ST_IDLE;
          else lane_idx_r <= lane_idx_r + LANE_W'(1);
        end
        ST_FIND: begin
          sel_r     <= found_idx;
          cmd_sym_r <= command_chars_r[{found_idx, 3'b000} +: 8];
          drain_k_r <= '0;
          if (found) begin
            state_r <= ST_INDEX;
          end else begin
            state_r       <= ST_IDLE;
            tok_pos_r     <= TP_BEFORE;
            data_length_r <= '0;
            overflow_r    <= 1'b0;
            for (int i = 0; i < MAX_COMMANDS; i++) begin
              lane_seen_r[i]     <= 1'b0;
              lane_phase_r[i]    <= PH_WAIT;
              lane_negative_r[i] <= 1'b0;
              lane_value_r[i]    <= '0;
            end
          end
        end
        ST_INDEX: begin
          cmd_index_r <= index_nxt;
          state_r     <= ST_DRAIN;
        end
        ST_DRAIN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_char_r  <= cmd_sym_r;
            out_index_r <= cmd_index_r;
            out_has_r   <= (data_length_r != '0);
            out_data_r  <= (data_length_r != '0) ? data_store[drain_k_r[AW-1:0]] : 8'h00;
            out_trunc_r <= overflow_r;
            out_last_r  <= drain_last;
            if (drain_last) begin
              state_r       <= ST_IDLE;
              tok_pos_r     <= TP_BEFORE;
              data_length_r <= '0;
              overflow_r    <= 1'b0;
              for (int i = 0; i < MAX_COMMANDS; i++) begin
                lane_seen_r[i]     <= 1'b0;
                lane_phase_r[i]    <= PH_WAIT;
                lane_negative_r[i] <= 1'b0;
                lane_value_r[i]    <= '0;
              end
            end else begin
              drain_k_r <= drain_k_r + LW'(1);
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    out_tdata             = '0;
    out_tdata[7:0]        = out_char_r;
    out_tdata[8 +: W]     = out_index_r;
    out_tdata[8 + W +: 8] = out_data_r;
  end

  assign out_tvalid                = out_valid_r;
  assign out_tuser[USER_HAS_DATA]  = out_has_r;
  assign out_tuser[USER_TRUNCATED] = out_trunc_r;
  assign out_tlast                 = out_last_r;

endmodule

FILE: hw/rtl/scfp_checker.sv
// Port-level checks of the serial command frame parser, bound to the top level.
module scfp_checker #(
  parameter int OUT_DW = 32
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [7:0]                      in_tdata,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [OUT_DW-1:0]               out_tdata,
  input logic [scfp_pkg::OUT_USER_W-1:0] out_tuser,
  input logic                            out_tlast
);
  import scfp_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result item dropped or changed while stalled");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[USER_HAS_DATA] |-> out_tlast)
    else $error("empty record is not the last item of its frame");

  a_busy_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input taken while a frame is still draining");

  a_frame_end_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tdata == CHAR_FRAME_END |=> !in_tready)
    else $error("input ready straight after a frame end");

endmodule

bind serial_command_frame_parser scfp_checker #(
  .OUT_DW(((16 + INDEX_WIDTH + 7) / 8) * 8)
) u_scfp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
